// ----- rtl/abc_pkg.sv -----
// Shared types, codes and arithmetic helpers for the alpha blend compositor.
`timescale 1ns / 1ps

package abc_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_BLEND = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW_X      = 2'd2;
  localparam logic [1:0] REG_WINDOW_Y      = 2'd3;

  // Register reset values.
  localparam logic [8:0] SCREEN_SIZE_RST = 9'd256;

  // Fully opaque alpha.
  localparam logic [7:0] ALPHA_MAX = 8'd255;

  // Clear sequencer states.
  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DONE  = 3'b100
  } clr_state_t;

  // Three color lanes: red, green, blue.
  typedef logic [2:0][7:0] rgb_t;

  // Exact floor(v / 255) for any 16-bit v below 65280.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + {9'b0, v[15:8]};
    return t[15:8];
  endfunction

endpackage

// ----- rtl/alpha_blend_compositor.sv -----
// A blend or read result passes through stage registers A, B and C to the output register.
// One blend or read is taken per cycle unless the output stalls or a clear is pending;
// the read-modify-write of the screen memory is forwarded from the two stages behind
// the read port. Clear waits for earlier requests to drain, then writes one entry per
// cycle over the width * height screen area.
// Reset (synchronous, active low) clears control state and sets the registers
// to 256, 256, 0, 0; the screen memory is undefined until a clear is run.
`timescale 1ns / 1ps

module alpha_blend_compositor
  import abc_pkg::*;
#(
  parameter int FB_WIDTH  = 256,
  parameter int FB_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0: column[9:0], row[9:0], src_red, src_green, src_blue,
  // src_alpha, then four zero bits.
  input  logic [55:0] in_tdata,
  // tuser from bit 0: opcode[1:0].
  input  logic [1:0]  in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0: out_red, out_green, out_blue, out_alpha.
  output logic [31:0] out_tdata,
  // tuser from bit 0: status.
  output logic [0:0]  out_tuser,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int MEM_DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int AW        = $clog2(MEM_DEPTH);

  // Configuration registers.
  logic [8:0]  scr_w_r, scr_h_r;
  logic [15:0] win_x_r, win_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_SIZE_RST;
      scr_h_r <= SCREEN_SIZE_RST;
      win_x_r <= '0;
      win_y_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_data[8:0];
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_data[8:0];
        REG_WINDOW_X:      win_x_r <= cfg_data;
        REG_WINDOW_Y:      win_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective screen size, limited to the memory geometry.
  logic [8:0] eff_w, eff_h;
  assign eff_w = ({23'b0, scr_w_r} > FB_WIDTH)  ? 9'(FB_WIDTH)  : scr_w_r;
  assign eff_h = ({23'b0, scr_h_r} > FB_HEIGHT) ? 9'(FB_HEIGHT) : scr_h_r;

  // Pipeline registers.
  logic          a_vld_r, b_vld_r, c_vld_r, out_vld_r;
  logic [1:0]    a_op_r, b_op_r, c_op_r;
  logic [9:0]    a_col_r, a_row_r;
  rgb_t          a_src_r, b_src_r;
  logic [7:0]    a_alpha_r, b_alpha_r;
  logic          b_clip_r, c_clip_r;
  logic [AW-1:0] b_addr_r, c_addr_r, w_addr_r;
  logic [2:0][15:0] c_sum_r;
  logic [31:0]   c_pix_r, w_data_r, rd_r;
  logic          w_vld_r;
  logic [31:0]   out_data_r;
  logic          out_status_r;

  // Clear sequencer.
  clr_state_t    st_r, st_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt, last_r, last_nxt;

  logic adv, a_ok, a_move;

  // The whole pipeline steps when the output register can take a result.
  assign adv    = !out_vld_r || out_tready;
  assign a_ok   = !a_vld_r || (a_op_r != OP_CLEAR) || (st_r == ST_DONE);
  assign a_move = adv && a_ok;
  assign in_tready = !a_vld_r || a_move;

  // Stage A: screen position, clipping and memory address.
  logic [16:0] pos_x, pos_y;
  logic        a_clip;
  logic [8:0]  sel_x, sel_y;
  logic [18:0] addr_full;
  logic [AW-1:0] a_addr;

  always_comb begin
    pos_x = {1'b0, win_x_r} + {7'b0, a_col_r};
    pos_y = {1'b0, win_y_r} + {7'b0, a_row_r};
    a_clip = 1'b0;
    sel_x = a_col_r[8:0];
    sel_y = a_row_r[8:0];
    case (a_op_r)
      OP_BLEND: begin
        a_clip = (pos_x >= {8'b0, eff_w}) || (pos_y >= {8'b0, eff_h});
        sel_x  = pos_x[8:0];
        sel_y  = pos_y[8:0];
      end
      OP_READ: begin
        a_clip = ({1'b0, a_col_r} >= {2'b0, eff_w}) || ({1'b0, a_row_r} >= {2'b0, eff_h});
      end
      default: ;
    endcase
    addr_full = ({10'b0, sel_y} * {10'b0, eff_w}) + {10'b0, sel_x};
    a_addr    = AW'(addr_full);
  end

  // Stage A register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      a_vld_r <= 1'b1;
    end else if (a_move) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_op_r    <= in_tuser;
      a_col_r   <= in_tdata[9:0];
      a_row_r   <= in_tdata[19:10];
      a_src_r   <= {in_tdata[43:36], in_tdata[35:28], in_tdata[27:20]};
      a_alpha_r <= in_tdata[51:44];
    end
  end

  // Clear sequencer: sweeps the screen area once earlier writes have drained.
  logic [17:0] area;
  assign area = {9'b0, eff_h} * {9'b0, eff_w};

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    unique case (st_r)
      ST_RUN: begin
        if (a_vld_r && (a_op_r == OP_CLEAR) && !b_vld_r && !c_vld_r) begin
          if (area == 18'd0) begin
            st_nxt = ST_DONE;
          end else begin
            st_nxt   = ST_SWEEP;
            cnt_nxt  = '0;
            last_nxt = AW'(area - 18'd1);
          end
        end
      end
      ST_SWEEP: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == last_r) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (adv) begin
          st_nxt = ST_RUN;
        end
      end
      default: st_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RUN;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
  end

  // Screen memory: one write port, one registered read port.
  logic [31:0] mem_q [MEM_DEPTH];
  logic        c_wr;
  logic [31:0] c_word;

  always_ff @(posedge clk) begin
    if (st_r == ST_SWEEP) begin
      mem_q[cnt_r] <= '0;
    end else if (adv && c_wr) begin
      mem_q[c_addr_r] <= c_word;
    end
    if (adv) begin
      rd_r <= mem_q[a_addr];
    end
  end

  // Stage B: pick the newest copy of the stored pixel and form the sums.
  logic [31:0]      dst;
  logic [2:0][15:0] b_sum;
  logic [7:0]       dst_weight;

  always_comb begin
    if (c_wr && (c_addr_r == b_addr_r)) begin
      dst = c_word;
    end else if (w_vld_r && (w_addr_r == b_addr_r)) begin
      dst = w_data_r;
    end else begin
      dst = rd_r;
    end
    dst_weight = ALPHA_MAX - b_alpha_r;
    for (int i = 0; i < 3; i++) begin
      b_sum[i] = ({8'b0, b_src_r[i]} * {8'b0, b_alpha_r})
               + ({8'b0, dst[8*i +: 8]} * {8'b0, dst_weight});
    end
  end

  // Stage C: divide by 255 and build the written word.
  always_comb begin
    c_wr   = c_vld_r && (c_op_r == OP_BLEND) && !c_clip_r;
    c_word = {ALPHA_MAX, div255(c_sum_r[2]), div255(c_sum_r[1]), div255(c_sum_r[0])};
  end

  // Stage B, C, write-history and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      w_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r   <= a_vld_r && a_ok;
      c_vld_r   <= b_vld_r;
      w_vld_r   <= c_wr;
      out_vld_r <= c_vld_r;
    end else if (st_r == ST_SWEEP) begin
      w_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op_r    <= a_op_r;
      b_clip_r  <= a_clip;
      b_addr_r  <= a_addr;
      b_src_r   <= a_src_r;
      b_alpha_r <= a_alpha_r;
      c_op_r    <= b_op_r;
      c_clip_r  <= b_clip_r;
      c_addr_r  <= b_addr_r;
      c_sum_r   <= b_sum;
      c_pix_r   <= dst;
      w_addr_r  <= c_addr_r;
      w_data_r  <= c_word;
      out_status_r <= c_clip_r;
      out_data_r   <= ((c_op_r == OP_READ) && !c_clip_r) ? c_pix_r : 32'd0;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_status_r;

`ifndef SYNTHESIS
  // The sweep never overlaps a pending write-back.
  a_sweep_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SWEEP) |-> (!b_vld_r && !c_vld_r))
    else $error("clear sweep running with requests in flight");

  // The sweep finishes after its last entry.
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_SWEEP) && (cnt_r == last_r)) |=> (st_r == ST_DONE))
    else $error("clear sweep did not end at its last entry");

  // A stalled output freezes the write-back stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> ($stable(c_vld_r) && $stable(c_addr_r)))
    else $error("write-back stage moved during an output stall");

  // A clipped or off-screen result carries no pixel.
  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_status_r) |-> (out_data_r == 32'd0))
    else $error("clipped result carries pixel data");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the alpha blend compositor request and result streams.
`timescale 1ns / 1ps

module tb
  import abc_pkg::*;
();

  localparam int FB_W = 256;
  localparam int FB_H = 256;
  localparam int SCREEN_WORDS = FB_W * FB_H;
  localparam int STALL_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 105;
  // Opcode the block treats as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] rgba;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Requests waiting to be sent and results still owed by the block.
  pixel_req_t    pending_reqs[$];
  pixel_result_t owed_pixels[$];

  // Shadow copy of the screen and of the geometry registers.
  logic [31:0] screen_img [0:SCREEN_WORDS-1];
  logic [8:0]  scr_w = SCREEN_SIZE_RST;
  logic [8:0]  scr_h = SCREEN_SIZE_RST;
  logic [15:0] win_x = '0;
  logic [15:0] win_y = '0;

  int errors = 0;
  int n_clear = 0, n_blend = 0, n_read = 0, n_unused = 0;
  int n_offscreen = 0, n_settings = 0;
  int burst_left = 0, gap_left = 0;
  int stall_cycles = 0;
  bit [31:0] rx_cycle = '0;

  string chan_name [4] = '{"red", "green", "blue", "alpha"};

  alpha_blend_compositor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Source-over of one channel, rounded down.
  function automatic logic [7:0] mix_channel(input int src, input int dst, input int a);
    return 8'((src * a + dst * (int'(ALPHA_MAX) - a)) / int'(ALPHA_MAX));
  endfunction

  // Update the shadow screen for one accepted request and queue the result it owes.
  task automatic apply_request(input logic [1:0] op, input logic [55:0] d);
    int w, h, x, y, col, row, idx, i;
    logic [31:0] old;
    pixel_result_t res;
    w = (scr_w > FB_W) ? FB_W : int'(scr_w);
    h = (scr_h > FB_H) ? FB_H : int'(scr_h);
    col = int'(d[9:0]);
    row = int'(d[19:10]);
    res = '0;
    case (op)
      OP_CLEAR: begin
        n_clear++;
        for (i = 0; i < w * h; i++) screen_img[i] = '0;
      end
      OP_BLEND: begin
        n_blend++;
        x = int'(win_x) + col;
        y = int'(win_y) + row;
        if (x >= w || y >= h) begin
          res.status = 1'b1;
        end else begin
          idx = (y * w + x) % SCREEN_WORDS;
          old = screen_img[idx];
          screen_img[idx] = {ALPHA_MAX,
                             mix_channel(int'(d[43:36]), int'(old[23:16]), int'(d[51:44])),
                             mix_channel(int'(d[35:28]), int'(old[15:8]), int'(d[51:44])),
                             mix_channel(int'(d[27:20]), int'(old[7:0]), int'(d[51:44]))};
        end
      end
      OP_READ: begin
        n_read++;
        if (col >= w || row >= h) res.status = 1'b1;
        else res.rgba = screen_img[(row * w + col) % SCREEN_WORDS];
      end
      default: n_unused++;
    endcase
    owed_pixels.push_back(res);
  endtask

  task automatic push_req(input logic [1:0] op, input int col, input int row,
                          input int r, input int g, input int b, input int a);
    pixel_req_t q;
    q.op = op;
    q.col = 10'(col);
    q.row = 10'(row);
    q.red = 8'(r);
    q.green = 8'(g);
    q.blue = 8'(b);
    q.alpha = 8'(a);
    pending_reqs.push_back(q);
  endtask

  function automatic int pick_alpha();
    int s;
    s = $urandom_range(0, 7);
    if (s == 0) return 0;
    if (s == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_size();
    int s;
    s = $urandom_range(0, 19);
    if (s == 0) return 0;
    if (s == 1) return $urandom_range(257, 511);
    if (s <= 3) return 256;
    return $urandom_range(1, 64);
  endfunction

  // Wait until nothing is queued, in flight or owed; sampled away from the edge.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || owed_pixels.size() != 0);
    @(posedge clk);
  endtask

  // Write all four geometry registers while the block is idle.
  task automatic set_geometry(input int w, input int h, input int x, input int y);
    int vals [4];
    logic [1:0] regs [4];
    int i;
    vals = '{w, h, x, y};
    regs = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_WINDOW_X, REG_WINDOW_Y};
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= 16'(vals[i]);
      do @(posedge clk);
      while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : drive_requests
    pixel_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {4'b0, nxt.alpha, nxt.blue, nxt.green, nxt.red, nxt.row, nxt.col};
        in_tuser <= nxt.op;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern cycles through ready, light, heavy and long stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[10:9])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= ($urandom_range(0, 3) != 0);
        2'd2: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= (rx_cycle[3:0] == 4'd0);
      endcase
    end
  end

  // Track register writes and predict each accepted request.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH: scr_w <= cfg_data[8:0];
        REG_SCREEN_HEIGHT: scr_h <= cfg_data[8:0];
        REG_WINDOW_X: win_x <= cfg_data;
        REG_WINDOW_Y: win_y <= cfg_data;
        default: ;
      endcase
    end
    if (rst_n && in_tvalid && in_tready) apply_request(in_tuser, in_tdata);
  end

  // Compare each result with the oldest owed one, field by field.
  always @(posedge clk) begin : check_results
    pixel_result_t e;
    int c;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tuser[0]) n_offscreen++;
      if (owed_pixels.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed, status %0d data %h",
                 $time, out_tuser[0], out_tdata);
      end else begin
        e = owed_pixels.pop_front();
        if (out_tuser[0] !== e.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, e.status, out_tuser[0]);
        end
        for (c = 0; c < 4; c++) begin
          if (out_tdata[8*c +: 8] !== e.rgba[8*c +: 8]) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, chan_name[c], e.rgba[8*c +: 8], out_tdata[8*c +: 8]);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no request, result or register write moves.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ph, k, w, h, we, he, wx, wy, sel, col, row;
    bit clear_ok;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry: the first clear defines every screen word.
    push_req(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    push_req(OP_READ, 0, 0, 0, 0, 0, 0);
    push_req(OP_BLEND, 0, 0, 255, 255, 255, 255);
    push_req(OP_BLEND, 0, 0, 0, 0, 0, 0);
    // Back-to-back blends of one pixel exercise the forwarding path.
    push_req(OP_BLEND, 0, 0, 8'h12, 8'h34, 8'h56, 8'h80);
    push_req(OP_BLEND, 0, 0, 8'h12, 8'h34, 8'h56, 8'h80);
    push_req(OP_READ, 0, 0, 0, 0, 0, 0);
    push_req(OP_BLEND, 255, 255, 255, 255, 255, 255);
    push_req(OP_READ, 255, 255, 0, 0, 0, 0);
    push_req(OP_BLEND, 256, 0, 1, 2, 3, 4);
    push_req(OP_BLEND, 1023, 1023, 255, 255, 255, 255);
    push_req(OP_READ, 256, 0, 0, 0, 0, 0);
    push_req(OP_READ, 0, 256, 0, 0, 0, 0);
    push_req(OP_READ, 1023, 1023, 0, 0, 0, 0);
    push_req(OP_UNUSED, 1023, 1023, 255, 255, 255, 255);
    push_req(OP_BLEND, 1, 0, 8'hc3, 8'h3c, 8'h99, 8'h40);
    push_req(OP_READ, 1, 0, 0, 0, 0, 0);
    wait_idle();

    // Oversized screen is used as the full frame buffer.
    set_geometry(511, 300, 0, 0);
    push_req(OP_BLEND, 255, 255, 8'h10, 8'h80, 8'hf0, 8'h80);
    push_req(OP_READ, 255, 255, 0, 0, 0, 0);
    push_req(OP_READ, 256, 0, 0, 0, 0, 0);
    wait_idle();

    // Window far out: the position must not wrap onto the screen.
    set_geometry(1, 1, 16'hffff, 16'hffff);
    push_req(OP_BLEND, 0, 0, 255, 255, 255, 255);
    push_req(OP_READ, 0, 0, 0, 0, 0, 0);
    wait_idle();

    // Zero width: clear does nothing and everything else is off screen.
    set_geometry(0, 5, 0, 0);
    push_req(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    push_req(OP_BLEND, 0, 0, 255, 255, 255, 255);
    push_req(OP_READ, 0, 0, 0, 0, 0, 0);
    wait_idle();

    // Random phases, each with its own geometry and window.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      w = pick_size();
      h = pick_size();
      we = (w > FB_W) ? FB_W : w;
      he = (h > FB_H) ? FB_H : h;
      wx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, we);
      wy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, he);
      clear_ok = (we * he <= 16384);
      set_geometry(w, h, wx, wy);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 2 && clear_ok) begin
          push_req(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
        end else if (sel >= 2 && sel < 5) begin
          push_req(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
        end else if (sel >= 5 && sel < 60) begin
          // Mostly aim inside the visible part of the window.
          if ($urandom_range(0, 7) == 0) begin
            col = $urandom_range(0, 1023);
            row = $urandom_range(0, 1023);
          end else begin
            col = (wx < we) ? $urandom_range(0, we - wx) : $urandom_range(0, 15);
            row = (wy < he) ? $urandom_range(0, he - wy) : $urandom_range(0, 15);
          end
          push_req(OP_BLEND, col, row, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), pick_alpha());
          // Often read the pixel straight back.
          if ($urandom_range(0, 2) == 0 && wx + col < we && wy + row < he)
            push_req(OP_READ, wx + col, wy + row, 0, 0, 0, 0);
        end else begin
          if ($urandom_range(0, 7) == 0) begin
            col = $urandom_range(0, 1023);
            row = $urandom_range(0, 1023);
          end else begin
            col = $urandom_range(0, we);
            row = $urandom_range(0, he);
          end
          push_req(OP_READ, col, row, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
        end
      end
      wait_idle();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d clears, %0d blends, %0d reads and %0d unused-opcode requests",
             n_clear, n_blend, n_read, n_unused);
    $display("across %0d geometry settings; %0d results were clipped or off screen.",
             n_settings, n_offscreen);
    if (errors == 0 && owed_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/abc_pkg.sv
rtl/alpha_blend_compositor.sv
tb/sv/tb.sv
